// ===== src/sc2x_pkg.sv =====
// Package for the Scale2x tile magnifier: pixel and neighbourhood types,
// configuration register indexes and port widths.
// No dependencies.
package sc2x_pkg;

	localparam int PIX_W      = 24;
	localparam int COORD_W    = 5;
	localparam int CFG_DATA_W = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 112;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 1'b1;

	localparam logic [CFG_DATA_W-1:0] TILE_SIZE_RESET = 6'd16;

	typedef logic [PIX_W-1:0] pix_t;

	// Neighbourhood captured when a source pixel is accepted.
	// cur is the new pixel, now1/now2 the two before it in the same row,
	// up0..up2 the row above at columns c, c-1, c-2, two0/two1 the row two
	// above at columns c and c-1.
	typedef struct packed {
		pix_t               cur;
		pix_t               now1;
		pix_t               now2;
		pix_t               up0;
		pix_t               up1;
		pix_t               up2;
		pix_t               two0;
		pix_t               two1;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               row_is0;
		logic               row_is1;
		logic               col_is0;
		logic               col_is1;
	} nbhd_t;

endpackage

// ===== src/sc2x_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sc2x_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== src/sc2x_window.sv =====
// Tile position counters, configuration registers, row memory and the
// sliding window that gathers each pixel's neighbourhood.
// Depends on sc2x_pkg and sc2x_ram.
module sc2x_window #(
	parameter int MAX_TILE = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [sc2x_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sc2x_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             accept,
	input  sc2x_pkg::pix_t                   pixel,
	output sc2x_pkg::nbhd_t                  nb,
	output logic [3:0]                       emit_mask
);

	localparam int CW = $clog2(MAX_TILE);
	localparam int SW = $clog2(MAX_TILE + 1);

	logic [sc2x_pkg::CFG_DATA_W-1:0] tile_width_q, tile_height_q;
	logic [CW-1:0] col_q, row_q, col_d, row_d;
	logic [SW-1:0] w_eff, h_eff;
	logic          last_col, last_row;

	// Each memory entry holds one column: row above in the low half,
	// row two above in the high half.
	logic [2*sc2x_pkg::PIX_W-1:0] rd_data, wr_data, byp_data_q;
	logic                         byp_q;
	sc2x_pkg::pix_t               up0, two0;
	sc2x_pkg::pix_t               now1_q, now2_q, up1_q, up2_q, two1_q;

	always_comb begin
		if (tile_width_q == '0) begin
			w_eff = SW'(1);
		end else if (9'(tile_width_q) > 9'(MAX_TILE)) begin
			w_eff = SW'(MAX_TILE);
		end else begin
			w_eff = SW'(tile_width_q);
		end
		if (tile_height_q == '0) begin
			h_eff = SW'(1);
		end else if (9'(tile_height_q) > 9'(MAX_TILE)) begin
			h_eff = SW'(MAX_TILE);
		end else begin
			h_eff = SW'(tile_height_q);
		end
	end

	assign last_col = ((SW+1)'(col_q) + (SW+1)'(1)) >= (SW+1)'(w_eff);
	assign last_row = ((SW+1)'(row_q) + (SW+1)'(1)) >= (SW+1)'(h_eff);

	always_comb begin
		col_d = col_q;
		row_d = row_q;
		if (cfg_wr_en) begin
			col_d = '0;
			row_d = '0;
		end else if (accept) begin
			if (last_col) begin
				col_d = '0;
				row_d = last_row ? '0 : row_q + CW'(1);
			end else begin
				col_d = col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q  <= sc2x_pkg::TILE_SIZE_RESET;
			tile_height_q <= sc2x_pkg::TILE_SIZE_RESET;
			col_q         <= '0;
			row_q         <= '0;
			byp_q         <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					sc2x_pkg::REG_TILE_WIDTH:  tile_width_q  <= cfg_data;
					sc2x_pkg::REG_TILE_HEIGHT: tile_height_q <= cfg_data;
					default: ;
				endcase
			end
			col_q <= col_d;
			row_q <= row_d;
			byp_q <= accept && (col_d == col_q);
		end
	end

	// The read address runs one column ahead so the entry is ready when
	// the pixel arrives. A one-column tile reads the entry just written.
	always_ff @(posedge clk) begin
		byp_data_q <= wr_data;
		if (accept) begin
			now1_q <= pixel;
			now2_q <= now1_q;
			up1_q  <= up0;
			up2_q  <= up1_q;
			two1_q <= two0;
		end
	end

	assign up0     = byp_q ? byp_data_q[sc2x_pkg::PIX_W-1:0] : rd_data[sc2x_pkg::PIX_W-1:0];
	assign two0    = byp_q ? byp_data_q[2*sc2x_pkg::PIX_W-1:sc2x_pkg::PIX_W]
	                       : rd_data[2*sc2x_pkg::PIX_W-1:sc2x_pkg::PIX_W];
	assign wr_data = {up0, pixel};

	sc2x_ram #(
		.WIDTH(2 * sc2x_pkg::PIX_W),
		.DEPTH(MAX_TILE)
	) u_rows (
		.clk    (clk),
		.wr_en  (accept),
		.wr_addr(col_q),
		.wr_data(wr_data),
		.rd_addr(col_d),
		.rd_data(rd_data)
	);

	always_comb begin
		nb.cur     = pixel;
		nb.now1    = now1_q;
		nb.now2    = now2_q;
		nb.up0     = up0;
		nb.up1     = up1_q;
		nb.up2     = up2_q;
		nb.two0    = two0;
		nb.two1    = two1_q;
		nb.row     = sc2x_pkg::COORD_W'(row_q);
		nb.col     = sc2x_pkg::COORD_W'(col_q);
		nb.row_is0 = (row_q == '0);
		nb.row_is1 = (row_q == CW'(1));
		nb.col_is0 = (col_q == '0);
		nb.col_is1 = (col_q == CW'(1));
		emit_mask[0] = (col_q != '0) && (row_q != '0);
		emit_mask[1] = (col_q != '0) && last_row;
		emit_mask[2] = last_col && (row_q != '0);
		emit_mask[3] = last_col && last_row;
	end

endmodule

// ===== src/sc2x_emit.sv =====
// Holds one accepted neighbourhood, applies the Scale2x rules to each of
// its pending results in turn and drives the output register.
// Depends on sc2x_pkg.
module sc2x_emit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  sc2x_pkg::nbhd_t                   nb_in,
	input  logic [3:0]                        mask_in,
	output logic                              in_ready,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sc2x_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tlast
);

	typedef enum logic [1:0] {
		SLOT_ABOVE_PREV,
		SLOT_LAST_PREV,
		SLOT_ABOVE_CUR,
		SLOT_LAST_CUR
	} slot_t;

	sc2x_pkg::nbhd_t nb_s1;
	logic [3:0]      mask_s1, clr;
	slot_t           slot;
	logic            adv, emit;

	sc2x_pkg::pix_t               pb, pd, pe, pf, ph;
	sc2x_pkg::pix_t               e0, e1, e2, e3;
	logic [sc2x_pkg::COORD_W-1:0] rsel, csel;
	logic                         done;

	always_comb begin
		if (mask_s1[0]) begin
			slot = SLOT_ABOVE_PREV;
		end else if (mask_s1[1]) begin
			slot = SLOT_LAST_PREV;
		end else if (mask_s1[2]) begin
			slot = SLOT_ABOVE_CUR;
		end else begin
			slot = SLOT_LAST_CUR;
		end
	end

	always_comb begin
		case (slot)
			SLOT_ABOVE_PREV: begin
				pe   = nb_s1.up1;
				pb   = nb_s1.row_is1 ? nb_s1.up1 : nb_s1.two1;
				pd   = nb_s1.col_is1 ? nb_s1.up1 : nb_s1.up2;
				pf   = nb_s1.up0;
				ph   = nb_s1.now1;
				rsel = nb_s1.row - 5'd1;
				csel = nb_s1.col - 5'd1;
				done = 1'b0;
				clr  = 4'b0001;
			end
			SLOT_LAST_PREV: begin
				pe   = nb_s1.now1;
				pb   = nb_s1.row_is0 ? nb_s1.now1 : nb_s1.up1;
				pd   = nb_s1.col_is1 ? nb_s1.now1 : nb_s1.now2;
				pf   = nb_s1.cur;
				ph   = nb_s1.now1;
				rsel = nb_s1.row;
				csel = nb_s1.col - 5'd1;
				done = 1'b0;
				clr  = 4'b0010;
			end
			SLOT_ABOVE_CUR: begin
				pe   = nb_s1.up0;
				pb   = nb_s1.row_is1 ? nb_s1.up0 : nb_s1.two0;
				pd   = nb_s1.col_is0 ? nb_s1.up0 : nb_s1.up1;
				pf   = nb_s1.up0;
				ph   = nb_s1.cur;
				rsel = nb_s1.row - 5'd1;
				csel = nb_s1.col;
				done = 1'b0;
				clr  = 4'b0100;
			end
			default: begin
				pe   = nb_s1.cur;
				pb   = nb_s1.row_is0 ? nb_s1.cur : nb_s1.up0;
				pd   = nb_s1.col_is0 ? nb_s1.cur : nb_s1.now1;
				pf   = nb_s1.cur;
				ph   = nb_s1.cur;
				rsel = nb_s1.row;
				csel = nb_s1.col;
				done = 1'b1;
				clr  = 4'b1000;
			end
		endcase
	end

	// Scale2x rules for the selected pixel.
	assign e0 = (pd == pb && pb != pf && pd != ph) ? pd : pe;
	assign e1 = (pb == pf && pb != pd && pf != ph) ? pf : pe;
	assign e2 = (pd == ph && pd != pb && ph != pf) ? pd : pe;
	assign e3 = (ph == pf && pd != ph && pb != pf) ? pf : pe;

	assign adv      = !m_tvalid || m_tready;
	assign emit     = (mask_s1 != 4'd0) && adv;
	assign in_ready = (mask_s1 == 4'd0) ||
	                  (adv && ((mask_s1 & (mask_s1 - 4'd1)) == 4'd0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s1  <= 4'd0;
			m_tvalid <= 1'b0;
		end else begin
			if (accept) begin
				mask_s1 <= mask_in;
			end else if (emit) begin
				mask_s1 <= mask_s1 & ~clr;
			end
			if (adv) begin
				m_tvalid <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			nb_s1 <= nb_in;
		end
		if (emit) begin
			m_tdata <= {6'd0, e3, e2, e1, e0, csel, rsel};
			m_tlast <= done;
		end
	end

endmodule

// ===== src/scale2x_tile_magnifier_unit.sv =====
// Scale2x tile magnifier, top level.
// An accepted pixel's neighbourhood is registered in the emit stage, then its first result
// word in the output register. Throughput: one result word per cycle while the output is
// not stalled; a pixel holds the input until the last of its results (up to four) leaves.
// Reset (arst_n, asynchronous, active low) clears counters and valid flags and sets both
// sizes to 16; the row memory is not cleared.
module scale2x_tile_magnifier_unit #(
	parameter int MAX_TILE = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration writes: index 0 is tile_width, index 1 is tile_height.
	input  logic                              cfg_wr_en,
	input  logic [sc2x_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sc2x_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Source pixel words.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sc2x_pkg::IN_DATA_W-1:0]    s_tdata,  // source_pixel[23:0]
	// Magnified result words.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// src_row[4:0], src_col[9:5], out_top_left[33:10], out_top_right[57:34],
	// out_bottom_left[81:58], out_bottom_right[105:82], zero pad[111:106]
	output logic [sc2x_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tlast   // tile_done
);

	// A word is taken when both tvalid and tready are high. The window
	// stage gathers the neighbourhood of the incoming pixel from the row
	// memory and from the pixels seen just before it, and the emit stage
	// works through that pixel's results one word per cycle unless the output stalls.
	sc2x_pkg::nbhd_t nb;
	logic [3:0]      emit_mask;
	logic            accept;

	assign accept = s_tvalid && s_tready;

	sc2x_window #(
		.MAX_TILE(MAX_TILE)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.pixel    (s_tdata[sc2x_pkg::PIX_W-1:0]),
		.nb       (nb),
		.emit_mask(emit_mask)
	);

	// The emit stage frees itself as its last pending word leaves, so a
	// new pixel can enter in the same cycle.
	sc2x_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.nb_in   (nb),
		.mask_in (emit_mask),
		.in_ready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

// ===== src/sc2x_checker.sv =====
// Port-level checks for the Scale2x tile magnifier, bound to the top level.
// Depends on sc2x_pkg and scale2x_tile_magnifier_unit.
module sc2x_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [sc2x_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                            m_tlast
);

	// A stalled result word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed while stalled");

	// With no new pixel offered, a ready input stays ready.
	a_ready_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && !s_tvalid |=> s_tready)
		else $error("input ready dropped with no pixel taken");

	// No result word straight out of reset.
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !m_tvalid)
		else $error("result word valid right after reset");

	// The pad bits of a result word are zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[111:106] == 6'd0)
		else $error("result word pad bits not zero");

endmodule

bind scale2x_tile_magnifier_unit sc2x_checker u_sc2x_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
